// ===== rtl/qte_pkg.sv =====
// Shared types, widths and the arctangent table for the quaternion to Euler angle converter.
// No dependencies; every design file imports this package.
package qte_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN = 24;
	localparam int TW = 34;          // width of a Q.30 term with headroom
	localparam int CW = 38;          // CORDIC x/y datapath width
	localparam int AW = 32;          // angle accumulator width, 2^31 = pi
	localparam int VW = 62;          // square root radicand width
	localparam int ROOT_BITS = 31;   // bits of the square root result
	localparam int ISQRT_LAT = ROOT_BITS + 2;

	typedef logic signed [TW-1:0] term_t;
	typedef logic signed [CW-1:0] cval_t;
	typedef logic [AW-1:0] angle_t;

	typedef struct packed {
		term_t t0;
		term_t t1;
		term_t t2;
		term_t t3;
		term_t t4;
	} terms_t;

	localparam term_t ONE_Q30 = term_t'(64'sd1 <<< 30);
	localparam angle_t QUARTER_TURN = 32'h4000_0000;
	localparam angle_t HALF_TURN = 32'h8000_0000;

	localparam angle_t ATAN_TAB [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	// Round half up to a 16-bit binary angle, wrapping.
	function automatic logic [15:0] round16(input angle_t a);
		angle_t s;
		s = a + 32'h0000_8000;
		return s[31:16];
	endfunction

endpackage

// ===== rtl/quaternion_to_euler_angles.sv =====
// Top level of the quaternion to Euler angle (ZYX) converter.
// Depends on qte_pkg, qte_terms, qte_isqrt and qte_cordic.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+------------------------------------------
//  request  | start / busy        | qx, qy, qz, qw (signed Q1.15)
//  result   | done (one cycle)    | roll_angle, pitch_angle, yaw_angle
//
// A new request is taken in every cycle; busy is held low since the pipeline
// never has to stop. Each result passes through the term stages, the
// one-bit-per-stage square root for the pitch cosine, and the CORDIC
// iteration stages.
// The receiver cannot stall, so results leave in request order with done high
// for exactly one cycle each. Reset clears only the valid bits of the pipeline.
module quaternion_to_euler_angles import qte_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] qx,
	input  logic signed [15:0] qy,
	input  logic signed [15:0] qz,
	input  logic signed [15:0] qw,
	output logic               done,
	output logic signed [15:0] roll_angle,
	output logic signed [15:0] pitch_angle,
	output logic signed [15:0] yaw_angle
);

	// Roll and yaw terms wait beside the square root pipeline.
	typedef struct packed {
		term_t ry;
		term_t rx;
		term_t yy;
		term_t yx;
	} ry_terms_t;

	logic accept;
	logic terms_vld;
	terms_t terms;
	logic sq_vld;
	term_t t2_d;
	logic [ROOT_BITS-1:0] cosv;
	ry_terms_t dly_s [ISQRT_LAT+1];

	logic roll_vld, pitch_vld, yaw_vld;
	angle_t roll_z, pitch_z, yaw_z;
	angle_t pitch_neg;
	logic signed [15:0] pitch_r;

	logic done_q;
	logic signed [15:0] roll_q, pitch_q, yaw_q;

	assign busy = 1'b0;
	assign accept = start && !busy;

	qte_terms u_terms (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (accept),
		.qx      (qx),
		.qy      (qy),
		.qz      (qz),
		.qw      (qw),
		.vld_out (terms_vld),
		.terms   (terms)
	);

	qte_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (terms_vld),
		.t2_in   (terms.t2),
		.vld_out (sq_vld),
		.t2_out  (t2_d),
		.root    (cosv)
	);

	assign dly_s[0] = '{ry: terms.t0, rx: terms.t1, yy: terms.t3, yx: terms.t4};

	// Payload-only delay line; the valid bit comes out of the square root unit.
	for (genvar k = 0; k < ISQRT_LAT; k++) begin : g_dly
		always_ff @(posedge clk) begin
			dly_s[k+1] <= dly_s[k];
		end
	end

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (sq_vld),
		.y_in    (dly_s[ISQRT_LAT].ry),
		.x_in    (dly_s[ISQRT_LAT].rx),
		.vld_out (roll_vld),
		.angle   (roll_z)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (sq_vld),
		.y_in    (t2_d),
		.x_in    ($signed(TW'(cosv))),
		.vld_out (pitch_vld),
		.angle   (pitch_z)
	);

	qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (sq_vld),
		.y_in    (dly_s[ISQRT_LAT].yy),
		.x_in    (dly_s[ISQRT_LAT].yx),
		.vld_out (yaw_vld),
		.angle   (yaw_z)
	);

	// Pitch is the negated arcsine, rounded and then limited to a quarter turn.
	assign pitch_neg = '0 - pitch_z;
	assign pitch_r = $signed(round16(pitch_neg));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= roll_vld && pitch_vld && yaw_vld;
		end
	end

	always_ff @(posedge clk) begin
		roll_q <= $signed(round16(roll_z));
		yaw_q <= $signed(round16(yaw_z));
		if (pitch_r > 16'sd16384) begin
			pitch_q <= 16'sd16384;
		end else if (pitch_r < -16'sd16384) begin
			pitch_q <= -16'sd16384;
		end else begin
			pitch_q <= pitch_r;
		end
	end

	assign done = done_q;
	assign roll_angle = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle = yaw_q;

endmodule

// ===== rtl/qte_terms.sv =====
// Two-stage product and sum pipeline forming the Q.30 terms of the conversion.
// Depends on qte_pkg.
module qte_terms import qte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_in,
	input  logic signed [15:0] qx,
	input  logic signed [15:0] qy,
	input  logic signed [15:0] qz,
	input  logic signed [15:0] qw,
	output logic               vld_out,
	output terms_t             terms
);

	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic vld_s1, vld_s2;
	terms_t terms_s2;
	term_t t2_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		wx_s1 <= qw * qx;
		yz_s1 <= qy * qz;
		xx_s1 <= qx * qx;
		yy_s1 <= qy * qy;
		wy_s1 <= qw * qy;
		zx_s1 <= qz * qx;
		wz_s1 <= qw * qz;
		xy_s1 <= qx * qy;
		zz_s1 <= qz * qz;
	end

	assign t2_raw = (TW'(wy_s1) - TW'(zx_s1)) <<< 1;

	always_ff @(posedge clk) begin
		terms_s2.t0 <= (TW'(wx_s1) + TW'(yz_s1)) <<< 1;
		terms_s2.t1 <= ONE_Q30 - ((TW'(xx_s1) + TW'(yy_s1)) <<< 1);
		if (t2_raw > ONE_Q30) begin
			terms_s2.t2 <= ONE_Q30;
		end else if (t2_raw < -ONE_Q30) begin
			terms_s2.t2 <= -ONE_Q30;
		end else begin
			terms_s2.t2 <= t2_raw;
		end
		terms_s2.t3 <= (TW'(wz_s1) + TW'(xy_s1)) <<< 1;
		terms_s2.t4 <= ONE_Q30 - ((TW'(yy_s1) + TW'(zz_s1)) <<< 1);
	end

	assign vld_out = vld_s2;
	assign terms = terms_s2;

endmodule

// ===== rtl/qte_isqrt.sv =====
// Pipelined cosine for the pitch term: squares the clamped sine, then takes the
// floor square root of 2^60 minus it, one result bit per stage. Depends on qte_pkg.
module qte_isqrt import qte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_in,
	input  term_t                t2_in,
	output logic                 vld_out,
	output term_t                t2_out,
	output logic [ROOT_BITS-1:0] root
);

	logic signed [31:0] s_in;
	logic signed [63:0] sq_full;
	logic [VW-1:0] sq_s1;
	term_t t2_s1;
	logic vld_s1;

	logic [VW-1:0] rem_s [ROOT_BITS+1];
	logic [VW-1:0] root_s [ROOT_BITS+1];
	term_t t2_s [ROOT_BITS+1];
	logic vld_s [ROOT_BITS+1];

	assign s_in = t2_in[31:0];
	assign sq_full = s_in * s_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1 <= sq_full[VW-1:0];
		t2_s1 <= t2_in;
		rem_s[0] <= (VW'(1) << 60) - sq_s1;
		root_s[0] <= '0;
		t2_s[0] <= t2_s1;
	end

	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_step
		localparam int SH = 2 * (ROOT_BITS - 1 - j);
		logic [VW-1:0] bitv, trial;
		assign bitv = VW'(1) << SH;
		assign trial = root_s[j] + bitv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			t2_s[j+1] <= t2_s[j];
			if (rem_s[j] >= trial) begin
				rem_s[j+1] <= rem_s[j] - trial;
				root_s[j+1] <= (root_s[j] >> 1) + bitv;
			end else begin
				rem_s[j+1] <= rem_s[j];
				root_s[j+1] <= root_s[j] >> 1;
			end
		end
	end

	assign vld_out = vld_s[ROOT_BITS];
	assign t2_out = t2_s[ROOT_BITS];
	assign root = root_s[ROOT_BITS][ROOT_BITS-1:0];

endmodule

// ===== rtl/qte_cordic.sv =====
// Pipelined CORDIC vectoring unit giving atan2(y, x) as a 32-bit binary angle.
// One register stage for quadrant folding, then one stage per iteration. Depends on qte_pkg.
module qte_cordic import qte_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   vld_in,
	input  term_t  y_in,
	input  term_t  x_in,
	output logic   vld_out,
	output angle_t angle
);

	cval_t x_s [STEPS+1];
	cval_t y_s [STEPS+1];
	angle_t z_s [STEPS+1];
	logic fix_s [STEPS+1];
	angle_t fixa_s [STEPS+1];
	logic vld_s [STEPS+1];

	cval_t xe, ye;
	assign xe = CW'(x_in);
	assign ye = CW'(y_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_in;
		end
	end

	// A zero y bypasses the iterations: the angle is zero or a half turn.
	always_ff @(posedge clk) begin
		fix_s[0] <= (y_in == '0);
		fixa_s[0] <= (x_in >= 0) ? '0 : HALF_TURN;
		if (x_in < 0) begin
			if (y_in >= 0) begin
				x_s[0] <= ye;
				y_s[0] <= -xe;
				z_s[0] <= QUARTER_TURN;
			end else begin
				x_s[0] <= -ye;
				y_s[0] <= xe;
				z_s[0] <= '0 - QUARTER_TURN;
			end
		end else begin
			x_s[0] <= xe;
			y_s[0] <= ye;
			z_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_iter
		cval_t dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			fix_s[i+1] <= fix_s[i];
			fixa_s[i+1] <= fixa_s[i];
			if (y_s[i] < 0) begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - ATAN_TAB[i];
			end else begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + ATAN_TAB[i];
			end
		end
	end

	assign vld_out = vld_s[STEPS];
	assign angle = fix_s[STEPS] ? fixa_s[STEPS] : z_s[STEPS];

endmodule

// ===== verif/qte_checker.sv =====
// Checker for the quaternion to Euler angle converter: predicts each result from the
// accepted requests and compares it with the done strobe. Self-contained; uses no package.
module qte_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] qx,
	input  logic signed [15:0] qy,
	input  logic signed [15:0] qz,
	input  logic signed [15:0] qw,
	input  logic               done,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	output int                 fail_count,
	output int                 pending,
	output int                 seen_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 16;

	typedef struct packed {
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] yaw;
	} euler_t;

	euler_t angle_queue[$];

	function automatic logic [31:0] arctan_tab(input int i);
		logic [31:0] tab [24];
		tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
			32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
			32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
		return tab[i];
	endfunction

	// Vectoring rotation: the angle of (xv, yv), 2^31 standing for pi.
	function automatic logic [31:0] vector_angle(input longint yv, input longint xv);
		logic [31:0] acc;
		longint tmp, dx, dy;
		acc = '0;
		if (yv == 0)
			return (xv >= 0) ? 32'h0 : 32'h8000_0000;
		if (xv < 0) begin
			tmp = xv;
			if (yv >= 0) begin
				xv = yv; yv = -tmp; acc = 32'h4000_0000;
			end else begin
				xv = -yv; yv = tmp; acc = 32'hC000_0000;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = yv >>> i;
			dy = xv >>> i;
			if (yv < 0) begin
				xv -= dx; yv += dy; acc -= arctan_tab(i);
			end else begin
				xv += dx; yv -= dy; acc += arctan_tab(i);
			end
		end
		return acc;
	endfunction

	function automatic longint floor_sqrt(input longint v);
		longint res, b;
		res = 0;
		b = 64'sd1 <<< 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b; res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] to_binary_angle(input logic [31:0] a);
		logic [31:0] s;
		s = a + 32'h8000;
		return s[31:16];
	endfunction

	function automatic euler_t predict_angles(input longint x, input longint y,
			input longint z, input longint w);
		longint one, s, c;
		logic [15:0] p16;
		euler_t e;
		one = 64'sd1 <<< 30;
		e.roll = to_binary_angle(vector_angle(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
		e.yaw = to_binary_angle(vector_angle(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
		s = 2 * (w * y - z * x);
		if (s > one) s = one;
		if (s < -one) s = -one;
		c = floor_sqrt(one * one - s * s);
		p16 = to_binary_angle(32'h0 - vector_angle(s, c));
		if ($signed(p16) > 16384) p16 = 16'sd16384;
		if ($signed(p16) < -16384) p16 = -16'sd16384;
		e.pitch = p16;
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		euler_t exp_e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			seen_count <= 0;
			pending <= 0;
			angle_queue.delete();
		end else begin
			if (done) begin
				seen_count <= seen_count + 1;
				if (angle_queue.size() == 0) begin
					$error("result with no request outstanding");
					errs++;
				end else begin
					exp_e = angle_queue.pop_front();
					if (roll_angle !== exp_e.roll) begin
						$error("roll_angle: expected %0d, got %0d",
							$signed(exp_e.roll), roll_angle);
						errs++;
					end
					if (pitch_angle !== exp_e.pitch) begin
						$error("pitch_angle: expected %0d, got %0d",
							$signed(exp_e.pitch), pitch_angle);
						errs++;
					end
					if (yaw_angle !== exp_e.yaw) begin
						$error("yaw_angle: expected %0d, got %0d",
							$signed(exp_e.yaw), yaw_angle);
						errs++;
					end
				end
			end
			if (start && !busy)
				angle_queue = {angle_queue, predict_angles(qx, qy, qz, qw)};
			if (errs != 0)
				fail_count <= fail_count + errs;
			pending <= angle_queue.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
// Top of the converter testbench: clock, reset, request stimulus and the verdict.
// Depends on quaternion_to_euler_angles and qte_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Pipeline depth of the block at its default CORDIC length.
	localparam int LATENCY = 53;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_REQUESTS = 500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [15:0] qx = '0, qy = '0, qz = '0, qw = '0;
	logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
	int fail_count, pending, seen_count;
	int cycle_count = 0;
	int idle_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	quaternion_to_euler_angles u_dut (
		.clk, .arst_n, .start, .busy, .qx, .qy, .qz, .qw,
		.done, .roll_angle, .pitch_angle, .yaw_angle
	);

	qte_checker u_checker (
		.clk, .arst_n, .start, .busy, .qx, .qy, .qz, .qw,
		.done, .roll_angle, .pitch_angle, .yaw_angle,
		.fail_count, .pending, .seen_count
	);

	// The watchdog is sized for every request waiting out the full pipeline and
	// the sender's gaps.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Offers one request and holds it until the block accepts it. When the sender
	// is idling, start goes low for a random gap first, each cycle idling with the
	// set chance. Start stays high between back-to-back requests.
	task automatic send_request(input logic [15:0] x, input logic [15:0] y,
			input logic [15:0] z, input logic [15:0] w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		qx <= x; qy <= y; qz <= z; qw <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// A random component: mostly uniform raw codes, sometimes extremes or zero.
	function automatic logic [15:0] rand_component();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_random(input int count);
		logic [15:0] c [4];
		int k;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(3);
			if ($urandom_range(3) == 0) begin
				// Whole raw patterns, non-unit quaternions included.
				foreach (c[i]) c[i] = rand_component();
			end else begin
				// Roughly normalized: one dominant axis with small others.
				foreach (c[i]) c[i] = 16'(int'($urandom_range(0, 16000)) - 8000);
				c[k] = ($urandom_range(1)) ? 16'(23170 + int'($urandom_range(9000)))
					: 16'(-23170 - int'($urandom_range(9000)));
			end
			send_request(c[0], c[1], c[2], c[3]);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: identity, the pure axis rotations, the zero vector,
		// the gimbal-lock poles where the pitch term saturates, the negative axis
		// case that wraps to -pi, and the most negative and positive codes.
		send_request(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
		send_request(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_request(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
		send_request(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
		send_request(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
		send_request(16'h8000, 16'h0000, 16'h0000, 16'h0000);
		send_request(16'h0000, 16'h8000, 16'h0000, 16'h0000);
		send_request(16'h0000, 16'h0000, 16'h8000, 16'h0000);
		send_request(16'h0000, 16'h0000, 16'h0000, 16'h8000);
		send_request(16'h0000, 16'h5A82, 16'h0000, 16'h5A82);
		send_request(16'h0000, 16'hA57E, 16'h0000, 16'h5A82);
		send_request(16'h5A82, 16'h0000, 16'h0000, 16'h5A82);
		send_request(16'h0000, 16'h0000, 16'h5A82, 16'h5A82);
		send_request(16'h4000, 16'h4000, 16'h4000, 16'h4000);
		send_request(16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_request(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_request(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_request(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(16'h0001, 16'h0000, 16'h0000, 16'hFFFF);

		// Random requests in three phases of sender idling.
		idle_pct = 9;
		send_random(RANDOM_REQUESTS / 3);
		idle_pct = 57;
		send_random(RANDOM_REQUESTS / 3);
		idle_pct = 0;
		send_random(RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3));
		start <= 1'b0;

		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("Converted %0d quaternions: axis, pole, zero and extreme codes, then",
			seen_count);
		$display("random raw and near-unit requests under light, heavy and no gaps.");
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/qte_pkg.sv
rtl/qte_terms.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_angles.sv
verif/qte_checker.sv
verif/tb_top.sv
